// ----- hdl/assert_macros.svh -----
// Assertion helpers for the region grow block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define NRG_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define NRG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/nrg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package nrg_pkg;

  localparam int GREY_W     = 8;
  localparam int NBR        = 8;
  localparam int CNT_W      = 4;
  localparam int SUM_W      = 11;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_MIN  = 2'd0,
    MODE_MEAN = 2'd1,
    MODE_MAX  = 2'd2
  } grow_mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROW_MODE      = 2'd0,
    REG_MEAN_MIN_COUNT = 2'd1,
    REG_MAX_MIN_COUNT  = 2'd2
  } cfg_reg_t;

  localparam logic [MODE_W-1:0] GROW_MODE_RST      = MODE_MIN;
  localparam logic [CNT_W-1:0]  MEAN_MIN_COUNT_RST = 4'd4;
  localparam logic [CNT_W-1:0]  MAX_MIN_COUNT_RST  = 4'd6;

  typedef logic [NBR-1:0][GREY_W-1:0] grey_vec_t;

  // Statistics over the foreground neighbours.
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  sum;
    logic [GREY_W-1:0] lo;   // all ones when no neighbour is foreground
    logic [GREY_W-1:0] hi;   // zero when no neighbour is foreground
  } nbr_stats_t;

endpackage

`default_nettype wire

// ----- hdl/nrg_pix_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface nrg_pix_if;
  logic                          valid;
  logic                          ready;
  logic                          center_unclassified;
  logic [nrg_pkg::GREY_W-1:0]    center_grey;
  logic [nrg_pkg::GREY_W-1:0]    grey_nw;
  logic [nrg_pkg::GREY_W-1:0]    grey_n;
  logic [nrg_pkg::GREY_W-1:0]    grey_ne;
  logic [nrg_pkg::GREY_W-1:0]    grey_w;
  logic [nrg_pkg::GREY_W-1:0]    grey_e;
  logic [nrg_pkg::GREY_W-1:0]    grey_sw;
  logic [nrg_pkg::GREY_W-1:0]    grey_s;
  logic [nrg_pkg::GREY_W-1:0]    grey_se;
  logic [nrg_pkg::NBR-1:0]       foreground_mask;

  modport source (
    output valid, center_unclassified, center_grey, grey_nw, grey_n, grey_ne,
           grey_w, grey_e, grey_sw, grey_s, grey_se, foreground_mask,
    input  ready
  );
  modport sink (
    input  valid, center_unclassified, center_grey, grey_nw, grey_n, grey_ne,
           grey_w, grey_e, grey_sw, grey_s, grey_se, foreground_mask,
    output ready
  );
endinterface

`default_nettype wire

// ----- hdl/nrg_res_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface nrg_res_if;
  logic valid;
  logic ready;
  logic becomes_foreground;

  modport source (output valid, becomes_foreground, input ready);
  modport sink (input valid, becomes_foreground, output ready);
endinterface

`default_nettype wire

// ----- hdl/nrg_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface nrg_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [nrg_pkg::CFG_IDX_W-1:0]     index;
  logic [nrg_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/nrg_stats.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nrg_stats (
  input  nrg_pkg::grey_vec_t           grey,
  input  logic [nrg_pkg::NBR-1:0]      mask,
  output nrg_pkg::nbr_stats_t          stats
);

  always_comb begin
    stats.count = '0;
    stats.sum   = '0;
    stats.lo    = '1;
    stats.hi    = '0;
    for (int i = 0; i < nrg_pkg::NBR; i++) begin
      if (mask[i]) begin
        stats.count = stats.count + nrg_pkg::CNT_W'(1);
        stats.sum   = stats.sum + nrg_pkg::SUM_W'(grey[i]);
        if (grey[i] < stats.lo) stats.lo = grey[i];
        if (grey[i] > stats.hi) stats.hi = grey[i];
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/nrg_decide.sv -----
`timescale 1ns / 1ps
`default_nettype none

module nrg_decide (
  input  logic                             unclassified,
  input  logic [nrg_pkg::GREY_W-1:0]       center,
  input  nrg_pkg::nbr_stats_t              stats,
  input  logic [nrg_pkg::MODE_W-1:0]       mode,
  input  logic [nrg_pkg::CNT_W-1:0]        mean_min_count,
  input  logic [nrg_pkg::CNT_W-1:0]        max_min_count,
  output logic                             grow
);

  localparam int PROD_W = nrg_pkg::GREY_W + nrg_pkg::CNT_W;

  logic [PROD_W-1:0] prod;
  logic              any_fg;

  assign prod   = PROD_W'(center) * PROD_W'(stats.count);
  assign any_fg = (stats.count != '0);

  always_comb begin
    grow = 1'b0;
    if (unclassified) begin
      unique case (mode)
        nrg_pkg::MODE_MIN:
          grow = any_fg && (center < stats.lo);
        // grey < mean, kept exact as grey * n < sum
        nrg_pkg::MODE_MEAN:
          grow = (stats.count >= mean_min_count) && (prod < PROD_W'(stats.sum));
        nrg_pkg::MODE_MAX:
          grow = (stats.count >= max_min_count) && (center < stats.hi);
        default:
          grow = 1'b0;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/neighbour_region_grow_core.sv -----
// Region grow decision for one pixel: each transaction on pix carries a 3x3
// neighbourhood, and one transaction on res reports whether the unclassified
// centre joins the foreground (minimum, mean or maximum rule, set through
// cfg). The block takes one pixel per clock; each pixel passes through the
// input register and then the result register, and the only thing
// that slows it is res.ready held low. cfg is always ready; write it only
// while no pixel is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module neighbour_region_grow_core (
  input  logic           clk,
  input  logic           rst,
  nrg_pix_if.sink        pix,
  nrg_res_if.source      res,
  nrg_cfg_if.sink        cfg
);

  logic [nrg_pkg::MODE_W-1:0]   grow_mode;
  logic [nrg_pkg::CNT_W-1:0]    mean_min_count;
  logic [nrg_pkg::CNT_W-1:0]    max_min_count;

  // input register
  logic                         a_valid;
  logic                         a_unclassified;
  logic [nrg_pkg::GREY_W-1:0]   a_center;
  nrg_pkg::grey_vec_t           a_grey;
  logic [nrg_pkg::NBR-1:0]      a_mask;
  logic                         a_move;

  // result register
  logic                         b_valid;
  logic                         b_grow;

  nrg_pkg::nbr_stats_t          stats;
  logic                         grow;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grow_mode      <= nrg_pkg::GROW_MODE_RST;
      mean_min_count <= nrg_pkg::MEAN_MIN_COUNT_RST;
      max_min_count  <= nrg_pkg::MAX_MIN_COUNT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        nrg_pkg::REG_GROW_MODE:      grow_mode      <= cfg.data[nrg_pkg::MODE_W-1:0];
        nrg_pkg::REG_MEAN_MIN_COUNT: mean_min_count <= cfg.data[nrg_pkg::CNT_W-1:0];
        nrg_pkg::REG_MAX_MIN_COUNT:  max_min_count  <= cfg.data[nrg_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign a_move    = a_valid && (!b_valid || res.ready);
  assign pix.ready = !a_valid || a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pix.ready) begin
      a_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pix.valid && pix.ready) begin
      a_unclassified <= pix.center_unclassified;
      a_center       <= pix.center_grey;
      a_grey         <= {pix.grey_se, pix.grey_s, pix.grey_sw, pix.grey_e,
                         pix.grey_w, pix.grey_ne, pix.grey_n, pix.grey_nw};
      a_mask         <= pix.foreground_mask;
    end
  end

  nrg_stats u_stats (
    .grey  (a_grey),
    .mask  (a_mask),
    .stats (stats)
  );

  nrg_decide u_decide (
    .unclassified   (a_unclassified),
    .center         (a_center),
    .stats          (stats),
    .mode           (grow_mode),
    .mean_min_count (mean_min_count),
    .max_min_count  (max_min_count),
    .grow           (grow)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!b_valid || res.ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_move) begin
      b_grow <= grow;
    end
  end

  assign res.valid              = b_valid;
  assign res.becomes_foreground = b_grow;

  `NRG_ASSERT_ALWAYS(a_rst_clears_res, clk, rst |=> !res.valid, "result valid after reset")
  `NRG_ASSERT(a_accept_loads, clk, rst, (pix.valid && pix.ready) |=> a_valid, "accepted pixel lost")
  `NRG_ASSERT(a_stage_holds, clk, rst, (a_valid && !a_move) |=> (a_valid && $stable(a_grey) && $stable(a_mask)), "stalled input register changed")
  `NRG_ASSERT(a_move_gives_res, clk, rst, a_move |=> res.valid, "moved pixel gave no result")
  `NRG_ASSERT(a_bad_mode_no_grow, clk, rst, (a_move && grow_mode != nrg_pkg::MODE_MIN && grow_mode != nrg_pkg::MODE_MEAN && grow_mode != nrg_pkg::MODE_MAX) |=> !res.becomes_foreground, "undefined mode grew a pixel")

endmodule

`default_nettype wire

// ----- tb/tb_neighbour_region_grow_core.sv -----
`timescale 1ns / 1ps

module tb_neighbour_region_grow_core;

  localparam int          CLK_HALF   = 6;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          NUM_PHASES = 12;
  localparam int          PHASE_PIXELS = 100;
  localparam int          HOLD_CYCLES = 300;
  localparam int          NO_MIN = 256;

  typedef struct packed {
    logic                       unclassified;
    logic [nrg_pkg::GREY_W-1:0] grey;
    nrg_pkg::grey_vec_t         nbr;    // nbr[0] = nw ... nbr[7] = se
    logic [nrg_pkg::NBR-1:0]    mask;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  nrg_pix_if pix ();
  nrg_res_if res ();
  nrg_cfg_if cfg ();

  neighbour_region_grow_core dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  always #CLK_HALF clk = ~clk;

  // Mirror of the block's settings, tracked from cfg transactions.
  logic [nrg_pkg::MODE_W-1:0] mode_q;
  logic [nrg_pkg::CNT_W-1:0]  mean_cnt_q;
  logic [nrg_pkg::CNT_W-1:0]  max_cnt_q;

  pixel_t pixel_q[$];
  logic   expected_grow[$];
  pixel_t cur_pixel;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_start = 1'b0;
  int          hold_left = 0;
  int          errors = 0;
  int          pixels_queued = 0;
  int          pixels_accepted = 0;
  int          results_seen = 0;
  int          grown_seen = 0;
  int          settings_used = 1;
  int unsigned cycle_cnt = 0;

  logic [3:0] phase_mode [NUM_PHASES] =
    '{4'd0, 4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd1, 4'd3, 4'd0, 4'd6, 4'd1};
  logic [3:0] phase_mean [NUM_PHASES] =
    '{4'd4, 4'd0, 4'd8, 4'd9, 4'd4, 4'd4, 4'd4, 4'd3, 4'd2, 4'd15, 4'd5, 4'd1};
  logic [3:0] phase_max  [NUM_PHASES] =
    '{4'd6, 4'd6, 4'd6, 4'd0, 4'd0, 4'd8, 4'd15, 4'd5, 4'd2, 4'd15, 4'd1, 4'd7};

  function automatic logic predict_grow(pixel_t p);
    int n;
    int sum;
    int lo;
    int hi;
    n   = 0;
    sum = 0;
    lo  = NO_MIN;
    hi  = 0;
    if (!p.unclassified) return 1'b0;
    for (int i = 0; i < nrg_pkg::NBR; i++) begin
      if (p.mask[i]) begin
        n++;
        sum += int'(p.nbr[i]);
        if (int'(p.nbr[i]) < lo) lo = int'(p.nbr[i]);
        if (int'(p.nbr[i]) > hi) hi = int'(p.nbr[i]);
      end
    end
    case (mode_q)
      nrg_pkg::MODE_MIN:  return (lo < NO_MIN) && (int'(p.grey) < lo);
      nrg_pkg::MODE_MEAN: return (n >= int'(mean_cnt_q)) && (int'(p.grey) * n < sum);
      nrg_pkg::MODE_MAX:  return (n >= int'(max_cnt_q)) && (int'(p.grey) < hi);
      default:            return 1'b0;
    endcase
  endfunction

  function automatic int clamp_grey(int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  // Neighbours cluster around a base value half the time so that the
  // comparisons against min, mean and max land on both sides.
  function automatic pixel_t random_pixel();
    pixel_t p;
    int base;
    base = $urandom_range(255);
    p.unclassified = ($urandom_range(7) != 0);
    for (int i = 0; i < nrg_pkg::NBR; i++) begin
      if ($urandom_range(1))
        p.nbr[i] = nrg_pkg::GREY_W'(clamp_grey(base + int'($urandom_range(24)) - 12));
      else
        p.nbr[i] = nrg_pkg::GREY_W'($urandom_range(255));
    end
    case ($urandom_range(7))
      0:       p.grey = 8'd0;
      1:       p.grey = 8'd255;
      2, 3:    p.grey = nrg_pkg::GREY_W'($urandom_range(255));
      default: p.grey = nrg_pkg::GREY_W'(clamp_grey(base + int'($urandom_range(20)) - 10));
    endcase
    case ($urandom_range(7))
      0:       p.mask = 8'h00;
      1:       p.mask = 8'hFF;
      default: p.mask = nrg_pkg::NBR'($urandom_range(255));
    endcase
    return p;
  endfunction

  function automatic pixel_t make_pixel(logic unc, logic [7:0] grey, nrg_pkg::grey_vec_t nbr,
                                        logic [7:0] mask);
    pixel_t p;
    p.unclassified = unc;
    p.grey         = grey;
    p.nbr          = nbr;
    p.mask         = mask;
    return p;
  endfunction

  // Driver: keeps valid up until the transaction is taken.
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        expected_grow.push_back(predict_grow(cur_pixel));
        pixels_accepted++;
      end
      if (!pix.valid || pix.ready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_pixel = pixel_q.pop_front();
          pix.valid               <= 1'b1;
          pix.center_unclassified <= cur_pixel.unclassified;
          pix.center_grey         <= cur_pixel.grey;
          pix.grey_nw             <= cur_pixel.nbr[0];
          pix.grey_n              <= cur_pixel.nbr[1];
          pix.grey_ne             <= cur_pixel.nbr[2];
          pix.grey_w              <= cur_pixel.nbr[3];
          pix.grey_e              <= cur_pixel.nbr[4];
          pix.grey_sw             <= cur_pixel.nbr[5];
          pix.grey_s              <= cur_pixel.nbr[6];
          pix.grey_se             <= cur_pixel.nbr[7];
          pix.foreground_mask     <= cur_pixel.mask;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and result-side backpressure.
  always @(posedge clk) begin
    logic exp_grow;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        results_seen++;
        if (res.becomes_foreground) grown_seen++;
        if (expected_grow.size() == 0) begin
          $error("becomes_foreground: result with no pixel pending, got %0d",
                 res.becomes_foreground);
          errors++;
        end else begin
          exp_grow = expected_grow.pop_front();
          if (res.becomes_foreground !== exp_grow) begin
            $error("becomes_foreground: expected %0d, actual %0d", exp_grow,
                   res.becomes_foreground);
            errors++;
          end
        end
      end
      res.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long hold-off on the result side.
  always @(posedge clk) begin
    if (hold_start)
      hold_left <= HOLD_CYCLES;
    else if (hold_left != 0)
      hold_left <= hold_left - 1;
  end

  always @(posedge clk) begin
    if (rst) begin
      mode_q     <= nrg_pkg::GROW_MODE_RST;
      mean_cnt_q <= nrg_pkg::MEAN_MIN_COUNT_RST;
      max_cnt_q  <= nrg_pkg::MAX_MIN_COUNT_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        nrg_pkg::REG_GROW_MODE:      mode_q     <= cfg.data[nrg_pkg::MODE_W-1:0];
        nrg_pkg::REG_MEAN_MIN_COUNT: mean_cnt_q <= cfg.data;
        nrg_pkg::REG_MAX_MIN_COUNT:  max_cnt_q  <= cfg.data;
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_cnt);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic cfg_write(nrg_pkg::cfg_reg_t idx, logic [nrg_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic configure(logic [3:0] mode_val, logic [3:0] mean_val, logic [3:0] max_val);
    cfg_write(nrg_pkg::REG_GROW_MODE, mode_val);
    cfg_write(nrg_pkg::REG_MEAN_MIN_COUNT, mean_val);
    cfg_write(nrg_pkg::REG_MAX_MIN_COUNT, max_val);
    settings_used++;
  endtask

  task automatic queue_pixel(pixel_t p);
    pixel_q.push_back(p);
    pixels_queued++;
  endtask

  // Wait until every queued pixel has produced its result, plus pipeline slack.
  task automatic drain();
    while (results_seen < pixels_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_directed();
    queue_pixel(make_pixel(1'b1, 8'd0,   {nrg_pkg::NBR{8'hFF}}, 8'hFF));
    queue_pixel(make_pixel(1'b1, 8'd255, {nrg_pkg::NBR{8'hFF}}, 8'hFF));
    // already classified centre never grows
    queue_pixel(make_pixel(1'b0, 8'd0,   {nrg_pkg::NBR{8'hFF}}, 8'hFF));
    // no foreground neighbours
    queue_pixel(make_pixel(1'b1, 8'd0,   {nrg_pkg::NBR{8'hFF}}, 8'h00));
    queue_pixel(make_pixel(1'b1, 8'd100,
                {8'd120, 8'd0, 8'd255, 8'd99, 8'd101, 8'd150, 8'd200, 8'd90},
                8'b0101_1110));
    // lone foreground neighbour just above the centre
    queue_pixel(make_pixel(1'b1, 8'd254, {nrg_pkg::NBR{8'hFF}}, 8'h80));
  endtask

  initial begin
    pix.valid               = 1'b0;
    pix.center_unclassified = 1'b0;
    pix.center_grey         = '0;
    pix.grey_nw             = '0;
    pix.grey_n              = '0;
    pix.grey_ne             = '0;
    pix.grey_w              = '0;
    pix.grey_e              = '0;
    pix.grey_sw             = '0;
    pix.grey_s              = '0;
    pix.grey_se             = '0;
    pix.foreground_mask     = '0;
    res.ready               = 1'b0;
    cfg.valid               = 1'b0;
    cfg.index               = nrg_pkg::REG_GROW_MODE;
    cfg.data                = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed set under reset settings (minimum rule), then under the mean and maximum rules and the undefined mode 3.
    queue_directed();
    drain();
    configure(nrg_pkg::CFG_DATA_W'(nrg_pkg::MODE_MEAN), 4'd4, 4'd6);
    queue_directed();
    drain();
    configure(nrg_pkg::CFG_DATA_W'(nrg_pkg::MODE_MAX), 4'd4, 4'd6);
    queue_directed();
    drain();
    configure(4'd3, 4'd0, 4'd0);
    queue_directed();
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      configure(phase_mode[ph], phase_mean[ph], phase_max[ph]);
      @(posedge clk);
      case (ph % 4)
        0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
        1: begin send_idle_pct <= 65; stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  stall_pct <= 65; end
        default: begin send_idle_pct <= 22; stall_pct <= 22; end
      endcase
      // result side stalls long while pixels keep coming
      if (ph == 0) hold_start <= 1'b1;
      @(posedge clk);
      hold_start <= 1'b0;
      for (int k = 0; k < PHASE_PIXELS; k++) queue_pixel(random_pixel());
      drain();
    end

    if (expected_grow.size() != 0) begin
      $error("becomes_foreground: %0d results never arrived", expected_grow.size());
      errors++;
    end

    $display("Checked %0d pixels over %0d register settings, all three rules and mode 3;",
             pixels_accepted, settings_used);
    $display("%0d of %0d results grew the centre pixel.", grown_seen, results_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- neighbour_region_grow_core.f -----
+incdir+hdl
hdl/nrg_pkg.sv
hdl/nrg_pix_if.sv
hdl/nrg_res_if.sv
hdl/nrg_cfg_if.sv
hdl/nrg_stats.sv
hdl/nrg_decide.sv
hdl/neighbour_region_grow_core.sv
tb/tb_neighbour_region_grow_core.sv
